@@ rtl/core/acc_pkg.sv @@
`default_nettype none

package acc_pkg;

    // Fixed field widths
    localparam int VEL_W      = 16;
    localparam int QUO_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Register indices on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VERTICAL_SPEED = 1'b1;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] THR_RESET  = 15'd3277;
    localparam logic [CFG_DATA_W-1:0] VMAX_RESET = 15'd256;

    // Ratio magnitude when one reading is zero: 32767 (clamped) if up is zero, 32768 if down is zero
    localparam logic [QUO_W:0] MAG_FULL_POS = 16'h7FFF;
    localparam logic [QUO_W:0] MAG_FULL_NEG = 16'h8000;

    // Q8.8 saturation limits on the widened sum
    localparam logic signed [VEL_W+1:0] VEL_SAT_HI = 18'sd32767;
    localparam logic signed [VEL_W+1:0] VEL_SAT_LO = -18'sd32768;
    localparam logic [VEL_W-1:0]        VEL_MAX    = 16'h7FFF;
    localparam logic [VEL_W-1:0]        VEL_MIN    = 16'h8000;

    // Side data travelling with the ratio divider
    typedef struct packed {
        logic signed [VEL_W-1:0] vel;
        logic                    neg;   // down < up
        logic                    zero;  // both readings zero
        logic                    full;  // exactly one reading zero
        logic [QUO_W-1:0]        quo;
    } ratio_side_t;

    // One stage of the proportional-term divider
    typedef struct packed {
        logic signed [VEL_W-1:0] vel;
        logic                    neg;
        logic                    outer; // beyond the outer threshold
        logic                    inner; // in the proportional band
        logic [QUO_W-1:0]        rem;
        logic [QUO_W-1:0]        low;   // dividend bits still to shift in
        logic [QUO_W-1:0]        quo;
    } prop_stage_t;

endpackage

`default_nettype wire

@@ rtl/core/altitude_centering_control.sv @@
`default_nettype none

// Altitude centering control. Each input transaction carries the upward and
// downward range readings and an upstream vertical velocity command; one result
// transaction returns the corrected Q8.8 command and a flag that is set when a
// saturated or proportional correction was applied. The block takes one
// transaction per clock unless stalled. An item passes through 33 registers: one
// input register, 15 stages of a radix-2 divider forming the Q1.15 offset ratio,
// one stage for the band tests and the speed-times-ratio product, 15 stages of a
// second radix-2 divider by the threshold, and the output register, which holds
// the sum and saturation. The two dividers, one quotient bit per stage, set the
// length of the pipeline. While the output waits, the pipeline keeps moving as
// long as its last divider stage is empty; once that stage holds an item, the
// whole pipeline and the input stall. The threshold and maximum speed registers
// are to be written over the cfg channel (index 0 and 1) by the user only while
// no transaction is in flight; the block itself does not enforce this.
module altitude_centering_control #(
    parameter int RANGE_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_axis_tdata: range_up, range_down, vel_z_in (from bit 0), zero padded
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [((2*RANGE_BITS+acc_pkg::VEL_W+7)/8)*8-1:0] s_axis_tdata,
    // m_axis_tdata: vel_z_out
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [acc_pkg::VEL_W-1:0]              m_axis_tdata,
    // m_axis_tuser: corrected
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [acc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [acc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import acc_pkg::*;

    localparam int DEN_W = RANGE_BITS + 1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] thr_reg;
    logic [CFG_DATA_W-1:0] vmax_reg;

    // Ratio divider stages: index 0 is the input register
    logic [DEN_W-1:0]  rem1_reg   [0:QUO_W];
    logic [DEN_W-1:0]  den1_reg   [0:QUO_W];
    ratio_side_t       side1_reg  [0:QUO_W];
    logic              v1_reg     [0:QUO_W];
    logic [DEN_W-1:0]  rem1_next  [1:QUO_W];
    ratio_side_t       side1_next [1:QUO_W];
    logic [DEN_W:0]    sh1        [1:QUO_W];
    logic [DEN_W:0]    sub1       [1:QUO_W];

    // Proportional divider stages: index 0 holds band tests and product
    prop_stage_t       prop_reg  [0:QUO_W];
    logic              v2_reg    [0:QUO_W];
    prop_stage_t       prop_next [1:QUO_W];
    logic [QUO_W:0]    sh2       [1:QUO_W];
    logic [QUO_W:0]    sub2      [1:QUO_W];

    // Output register
    logic              m_valid_reg;
    logic [VEL_W-1:0]  vel_out_reg;
    logic              corr_out_reg;

    // Pipeline flow control
    logic              out_load;
    logic              adv;

    assign out_load      = !m_valid_reg || m_axis_tready;
    assign adv           = out_load || !v2_reg[QUO_W];
    assign s_axis_tready = adv;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = vel_out_reg;
    assign m_axis_tuser  = corr_out_reg;
    assign cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            vmax_reg <= VMAX_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OFFSET_THRESHOLD:   thr_reg  <= cfg_data;
                REG_MAX_VERTICAL_SPEED: vmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input unpacking and ratio numerator / denominator
    logic [RANGE_BITS-1:0] up_in;
    logic [RANGE_BITS-1:0] down_in;
    logic [RANGE_BITS-1:0] diff_in;
    logic [DEN_W-1:0]      den_in;
    ratio_side_t           side_in;

    always_comb begin
        up_in   = s_axis_tdata[RANGE_BITS-1:0];
        down_in = s_axis_tdata[2*RANGE_BITS-1:RANGE_BITS];
        den_in  = {1'b0, up_in} + {1'b0, down_in};
        diff_in = (down_in >= up_in) ? (down_in - up_in) : (up_in - down_in);
        side_in.vel  = s_axis_tdata[2*RANGE_BITS+VEL_W-1:2*RANGE_BITS];
        side_in.neg  = up_in > down_in;
        side_in.zero = (up_in == '0) && (down_in == '0);
        side_in.full = ((up_in == '0) || (down_in == '0)) && !side_in.zero;
        side_in.quo  = '0;
    end

    // Ratio divider: one restoring step per stage, |num| < den on entry unless a reading is zero
    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            sh1[k]        = {rem1_reg[k-1], 1'b0};
            sub1[k]       = sh1[k] - {1'b0, den1_reg[k-1]};
            side1_next[k] = side1_reg[k-1];
            if (sh1[k] >= {1'b0, den1_reg[k-1]}) begin
                rem1_next[k]      = sub1[k][DEN_W-1:0];
                side1_next[k].quo = {side1_reg[k-1].quo[QUO_W-2:0], 1'b1};
            end else begin
                rem1_next[k]      = sh1[k][DEN_W-1:0];
                side1_next[k].quo = {side1_reg[k-1].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Band tests and product on the finished ratio
    ratio_side_t      s1_last;
    logic [QUO_W:0]   mag_a;
    logic [QUO_W+4:0] mag10_a;
    logic [30:0]      prod_a;
    prop_stage_t      prop_in;

    always_comb begin
        s1_last = side1_reg[QUO_W];
        if (s1_last.zero) begin
            mag_a = '0;
        end else if (s1_last.full) begin
            mag_a = s1_last.neg ? MAG_FULL_NEG : MAG_FULL_POS;
        end else begin
            mag_a = {1'b0, s1_last.quo};
        end
        mag10_a = {1'b0, mag_a, 3'b000} + {3'b000, mag_a, 1'b0};
        prod_a  = 31'(vmax_reg) * 31'(mag_a);
        prop_in.vel   = s1_last.vel;
        prop_in.neg   = s1_last.neg;
        prop_in.outer = mag_a > {1'b0, thr_reg};
        prop_in.inner = !prop_in.outer && (mag10_a > {5'b00000, thr_reg});
        // In the proportional band the product is below thr * 2^15
        prop_in.rem   = prod_a[29:15];
        prop_in.low   = prod_a[14:0];
        prop_in.quo   = '0;
    end

    // Proportional divider by the threshold, one quotient bit per stage
    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            prop_next[k] = prop_reg[k-1];
            sh2[k]  = {prop_reg[k-1].rem, prop_reg[k-1].low[QUO_W-1]};
            sub2[k] = sh2[k] - {1'b0, thr_reg};
            prop_next[k].low = {prop_reg[k-1].low[QUO_W-2:0], 1'b0};
            if (sh2[k] >= {1'b0, thr_reg}) begin
                prop_next[k].rem = sub2[k][QUO_W-1:0];
                prop_next[k].quo = {prop_reg[k-1].quo[QUO_W-2:0], 1'b1};
            end else begin
                prop_next[k].rem = sh2[k][QUO_W-1:0];
                prop_next[k].quo = {prop_reg[k-1].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Correction, sum and saturation
    prop_stage_t             p_last;
    logic signed [VEL_W:0]   corr_f;
    logic signed [VEL_W+1:0] sum_f;
    logic [VEL_W-1:0]        vel_sat;

    always_comb begin
        p_last = prop_reg[QUO_W];
        if (p_last.outer) begin
            corr_f = p_last.neg ? $signed({2'b00, vmax_reg}) : -$signed({2'b00, vmax_reg});
        end else if (p_last.inner) begin
            corr_f = p_last.neg ? $signed({2'b00, p_last.quo})
                                : -$signed({2'b00, p_last.quo});
        end else begin
            corr_f = '0;
        end
        sum_f = {{2{p_last.vel[VEL_W-1]}}, p_last.vel} + {corr_f[VEL_W], corr_f};
        if (sum_f > VEL_SAT_HI) begin
            vel_sat = VEL_MAX;
        end else if (sum_f < VEL_SAT_LO) begin
            vel_sat = VEL_MIN;
        end else begin
            vel_sat = sum_f[VEL_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QUO_W; k++) begin
                v1_reg[k] <= 1'b0;
                v2_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg[0] <= s_axis_tvalid;
                v2_reg[0] <= v1_reg[QUO_W];
                for (int k = 1; k <= QUO_W; k++) begin
                    v1_reg[k] <= v1_reg[k-1];
                    v2_reg[k] <= v2_reg[k-1];
                end
            end
            if (out_load) begin
                m_valid_reg <= v2_reg[QUO_W];
            end
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem1_reg[0]  <= {1'b0, diff_in};
            den1_reg[0]  <= den_in;
            side1_reg[0] <= side_in;
            for (int k = 1; k <= QUO_W; k++) begin
                rem1_reg[k]  <= rem1_next[k];
                den1_reg[k]  <= den1_reg[k-1];
                side1_reg[k] <= side1_next[k];
                prop_reg[k]  <= prop_next[k];
            end
            prop_reg[0] <= prop_in;
        end
        if (out_load && v2_reg[QUO_W]) begin
            vel_out_reg  <= vel_sat;
            corr_out_reg <= p_last.outer || p_last.inner;
        end
    end

`ifndef ASSERT_OFF
    // A finished item waiting behind a stalled output blocks the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready && v2_reg[QUO_W]) |-> !s_axis_tready)
        else $error("input accepted while the last stage could not drain");

    // Without a correction the command passes through untouched
    a_dead_band_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && v2_reg[QUO_W] && !p_last.outer && !p_last.inner)
        |=> (vel_out_reg == $past(p_last.vel)) && !corr_out_reg)
        else $error("dead band altered the velocity command");

    // Ratio divider keeps its remainder below the denominator
    a_ratio_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg[QUO_W] && !side1_reg[QUO_W].zero && !side1_reg[QUO_W].full)
        |-> (rem1_reg[QUO_W] < den1_reg[QUO_W]))
        else $error("ratio divider remainder out of range");
`endif

endmodule

`default_nettype wire
